FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

FILE: design/vfpq_pkg.sv
// Types, constants and command codes of the frame pacing queue
package vfpq_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int HANDLE_W = 16;
   localparam int TIME_W   = 40;
   localparam int DUR_W    = 32;
   localparam int DELAY_W  = 32;
   localparam int DROP_W   = 32;
   localparam int FILL_W   = 3;
   localparam int CMD_W    = 3;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 88;

   localparam logic [DELAY_W-1:0] DEFAULT_DELAY_RST = 32'd10000;
   localparam logic [FILL_W-1:0]  FILL_LIMIT_RST    = 3'd3;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RENDER = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;

   localparam logic CSR_DEFAULT_DELAY = 1'b0;
   localparam logic CSR_FILL_LIMIT    = 1'b1;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   pts;
      logic [DUR_W-1:0]    dur;
   } vfpq_entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } vfpq_cell_ctl_type;

endpackage

FILE: design/video_frame_pacing_queue_top.sv
// Top level of the frame pacing queue: command sequencer, cell chain and result register
// Frames sit in a chain of QUEUE_DEPTH cells with the head in cell 0; a pop shifts every cell
// one place towards the head at once. One request is worked at a time and req_tready is
// high between requests. Push, flush, start, stop, unused commands and a render that shows
// the head frame unchanged or shows nothing pass through the decide step and reach the result
// register. A render that advances drops the old head in the decide step; a scan step then
// skips, one frame per cycle, every later frame that is already due, and when frames remain
// a difference step and a settle step work out the delay. The next request is taken in the
// cycle after the result is loaded. A new request is taken while the previous result still
// waits in the output register; a stalled output then holds that request in its last step
// and keeps req_tready low.
`include "assert_macros.svh"

module video_frame_pacing_queue_top import vfpq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // frame_handle, frame_pts_us, frame_duration_us, clock_now_us, clock_valid, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // shown_handle, next_delay_us, drop_count, can_accept, push_rejected, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // frame_valid
   output logic                  rsp_tuser,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [DELAY_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;
   localparam int B_W   = TIME_W + 2;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DIFF   = 3'd3;
   localparam logic [2:0] ST_SETTLE = 3'd4;
   localparam logic [2:0] ST_HOLD   = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 playing_ff, playing_in;
   logic [DROP_W-1:0]    drop_ff, drop_in;
   logic [DELAY_W-1:0]   dflt_delay_ff;
   logic [FILL_W-1:0]    fill_limit_ff;

   logic [CMD_W-1:0]     cmd_ff;
   logic [TIME_W-1:0]    now_ff;
   logic                 now_ok_ff;
   vfpq_entry_type       push_entry_ff;

   logic [TIME_W-1:0]    a_ff, a_in;
   logic signed [B_W-1:0] b_ff, b_in;
   logic signed [B_W-1:0] d_min;
   logic [DELAY_W-1:0]   settle_delay;

   logic                 res_valid_ff, res_valid_in;
   logic [HANDLE_W-1:0]  res_handle_ff, res_handle_in;
   logic [DELAY_W-1:0]   res_delay_ff, res_delay_in;
   logic                 res_rej_ff, res_rej_in;

   logic                 rsp_valid_ff;
   logic                 rsp_frame_ff;
   logic [HANDLE_W-1:0]  rsp_handle_ff;
   logic [DELAY_W-1:0]   rsp_delay_ff;
   logic [DROP_W-1:0]    rsp_drop_ff;
   logic                 rsp_can_ff;
   logic                 rsp_rej_ff;

   logic                 shift_en;
   logic                 push_we;
   logic                 req_take;
   logic                 rsp_load;

   vfpq_entry_type       cell_q    [QUEUE_DEPTH];
   vfpq_entry_type       cell_next [QUEUE_DEPTH];
   vfpq_cell_ctl_type    cell_ctl  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_due;

   // Cell chain
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i < QUEUE_DEPTH - 1) begin : g_mid
         assign cell_next[i] = cell_q[i+1];
      end else begin : g_tail
         assign cell_next[i] = '0;
      end
      assign cell_ctl[i].shift = shift_en;
      assign cell_ctl[i].load  = push_we && (count_ff == CNT_W'(i));

      vfpq_cell u_cell (
         .clock   (clock),
         .ctl     (cell_ctl[i]),
         .shift_d (cell_next[i]),
         .load_d  (push_entry_ff),
         .now     (now_ff),
         .q       (cell_q[i]),
         .due     (cell_due[i])
      );
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);

   // Smaller of the two gaps, floored at zero and saturated to the delay width
   always_comb begin
      d_min = ($signed({2'b00, a_ff}) < b_ff) ? $signed({2'b00, a_ff}) : b_ff;
      if (d_min < 0) begin
         settle_delay = '0;
      end else if (d_min[B_W-1:DELAY_W] != '0) begin
         settle_delay = '1;
      end else begin
         settle_delay = d_min[DELAY_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      playing_in    = playing_ff;
      drop_in       = drop_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      res_valid_in  = res_valid_ff;
      res_handle_in = res_handle_ff;
      res_delay_in  = res_delay_ff;
      res_rej_in    = res_rej_ff;
      shift_en      = 1'b0;
      push_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_valid_in  = 1'b0;
            res_handle_in = '0;
            res_delay_in  = dflt_delay_ff;
            res_rej_in    = 1'b0;
            state_in      = ST_HOLD;
            unique case (cmd_ff)
               CMD_PUSH: begin
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     res_rej_in = 1'b1;
                  end else begin
                     push_we  = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               CMD_RENDER: begin
                  if (playing_ff && (count_ff != '0) && now_ok_ff) begin
                     if (cell_due[0] && (count_ff > CNT_W'(1))) begin
                        // drop the old head; cell 1 becomes the current frame
                        shift_en = 1'b1;
                        count_in = count_ff - CNT_W'(1);
                        state_in = ST_SCAN;
                     end else begin
                        res_valid_in  = 1'b1;
                        res_handle_in = cell_q[0].handle;
                     end
                  end
               end
               CMD_FLUSH: count_in   = '0;
               CMD_START: playing_in = 1'b1;
               CMD_STOP:  playing_in = 1'b0;
               default: ;
            endcase
         end
         ST_SCAN: begin
            if ((count_ff > CNT_W'(1)) && cell_due[1]) begin
               // skip the current frame, a later one is due as well
               shift_en = 1'b1;
               count_in = count_ff - CNT_W'(1);
               drop_in  = drop_ff + DROP_W'(1);
            end else begin
               res_valid_in  = 1'b1;
               res_handle_in = cell_q[0].handle;
               state_in      = (count_ff > CNT_W'(1)) ? ST_DIFF : ST_HOLD;
            end
         end
         ST_DIFF: begin
            a_in = cell_q[1].pts - now_ff;
            b_in = $signed({2'b00, cell_q[0].pts}
                           + {{(B_W-DUR_W){1'b0}}, cell_q[0].dur}
                           - {2'b00, now_ff});
            state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            res_delay_in = settle_delay;
            state_in     = ST_HOLD;
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         playing_ff    <= 1'b0;
         drop_ff       <= '0;
         dflt_delay_ff <= DEFAULT_DELAY_RST;
         fill_limit_ff <= FILL_LIMIT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         playing_ff <= playing_in;
         drop_ff    <= drop_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DEFAULT_DELAY: dflt_delay_ff <= csr_wdata;
               CSR_FILL_LIMIT:    fill_limit_ff <= csr_wdata[FILL_W-1:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff               <= req_tuser;
         push_entry_ff.handle <= req_tdata[15:0];
         push_entry_ff.pts    <= req_tdata[55:16];
         push_entry_ff.dur    <= req_tdata[87:56];
         now_ff               <= req_tdata[127:88];
         now_ok_ff            <= req_tdata[128];
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      res_valid_ff  <= res_valid_in;
      res_handle_ff <= res_handle_in;
      res_delay_ff  <= res_delay_in;
      res_rej_ff    <= res_rej_in;
      if (rsp_load) begin
         rsp_frame_ff  <= res_valid_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_delay_ff  <= res_delay_ff;
         rsp_drop_ff   <= drop_ff;
         rsp_can_ff    <= (CMP_W'(count_ff) < CMP_W'(fill_limit_ff));
         rsp_rej_ff    <= res_rej_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_frame_ff;
   assign rsp_tdata  = {6'b0, rsp_rej_ff, rsp_can_ff, rsp_drop_ff, rsp_delay_ff, rsp_handle_ff};

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `ASSERT_IMPLIES(a_scan_nonempty, clock, reset, state_ff == ST_SCAN, count_ff != '0)
   `ASSERT_NEXT(a_drop_only_in_scan, clock, reset, state_ff != ST_SCAN, $stable(drop_ff))

endmodule

FILE: design/vfpq_cell.sv
// One queue cell: holds a frame, shifts towards the head or takes a pushed frame
module vfpq_cell import vfpq_pkg::*; (
   input  logic                clock,
   input  vfpq_cell_ctl_type   ctl,
   input  vfpq_entry_type      shift_d,
   input  vfpq_entry_type      load_d,
   input  logic [TIME_W-1:0]   now,
   output vfpq_entry_type      q,
   output logic                due
);

   vfpq_entry_type entry_ff;

   always_ff @(posedge clock) begin
      priority if (ctl.shift) begin
         entry_ff <= shift_d;
      end else if (ctl.load) begin
         entry_ff <= load_d;
      end else begin
         entry_ff <= entry_ff;
      end
   end

   assign q   = entry_ff;
   assign due = (entry_ff.pts <= now);

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the video frame pacing queue
`timescale 1ns / 100ps

module tb;
   import vfpq_pkg::*;

   localparam int          STALL_LIMIT  = 2000;
   localparam int          SETTLE_TICKS = 12;
   localparam int          LONG_HOLD    = 300;
   localparam int          PHASE_ITEMS  = 125;
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam longint      DELAY_CEIL   = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   pts;
      logic [DUR_W-1:0]    dur;
      logic [TIME_W-1:0]   now;
      logic                now_ok;
   } pacing_request_type;

   typedef struct packed {
      logic                shown;
      logic [HANDLE_W-1:0] handle;
      logic [DELAY_W-1:0]  delay;
      logic [DROP_W-1:0]   drops;
      logic                can_accept;
      logic                rejected;
   } pacing_verdict_type;

   class pacing_scoreboard_type;
      vfpq_entry_type   frames[$];
      bit               playing;
      logic [DROP_W-1:0]  dropped;
      logic [DELAY_W-1:0] dflt_delay;
      logic [FILL_W-1:0]  fill_limit;
      pacing_verdict_type pending_verdicts[$];
      int               faults;

      function new();
         playing    = 1'b0;
         dropped    = '0;
         dflt_delay = DEFAULT_DELAY_RST;
         fill_limit = FILL_LIMIT_RST;
         faults     = 0;
      endfunction

      function void write_reg(logic index, logic [DELAY_W-1:0] value);
         if (index == CSR_DEFAULT_DELAY)
            dflt_delay = value;
         else
            fill_limit = value[FILL_W-1:0];
      endfunction

      // Work out the result of one accepted request and queue it
      function void note_request(pacing_request_type r);
         pacing_verdict_type v;
         vfpq_entry_type  cur;
         longint          now64, t_next, t_end, a, b, d;
         v = '0;
         v.delay = dflt_delay;
         case (r.cmd)
            CMD_PUSH: begin
               if (frames.size() >= QUEUE_DEPTH_DEF)
                  v.rejected = 1'b1;
               else
                  frames.push_back(vfpq_entry_type'{handle: r.handle, pts: r.pts, dur: r.dur});
            end
            CMD_RENDER: begin
               if (playing && frames.size() > 0 && r.now_ok) begin
                  if (frames[0].pts <= r.now && frames.size() > 1) begin
                     frames.delete(0);
                     cur = frames[0];
                     frames.delete(0);
                     // drop every later frame that is already due
                     while (frames.size() > 0 && frames[0].pts <= r.now) begin
                        cur = frames[0];
                        frames.delete(0);
                        dropped++;
                     end
                     if (frames.size() > 0) begin
                        now64  = longint'(r.now);
                        t_next = longint'(frames[0].pts);
                        t_end  = longint'(cur.pts) + longint'(cur.dur);
                        a = t_next - now64;
                        b = t_end - now64;
                        d = (a < b) ? a : b;
                        if (d < 0)
                           d = 0;
                        if (d > DELAY_CEIL)
                           d = DELAY_CEIL;
                        v.delay = d[DELAY_W-1:0];
                     end
                     frames.insert(0, cur);
                  end
                  v.shown  = 1'b1;
                  v.handle = frames[0].handle;
               end
            end
            CMD_FLUSH: frames.delete();
            CMD_START: playing = 1'b1;
            CMD_STOP:  playing = 1'b0;
            default: ;
         endcase
         v.drops      = dropped;
         v.can_accept = (frames.size() < fill_limit);
         pending_verdicts.push_back(v);
      endfunction

      function string describe(pacing_verdict_type v);
         return $sformatf("shown=%0b handle=%h delay=%0d drops=%0d can_accept=%0b rejected=%0b",
                          v.shown, v.handle, v.delay, v.drops, v.can_accept, v.rejected);
      endfunction

      function void log_fault(string what);
         faults++;
         if (faults <= 10)
            $display("%0t: %s", $realtime, what);
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data, logic shown);
         pacing_verdict_type want, got;
         got.shown      = shown;
         got.handle     = data[15:0];
         got.delay      = data[47:16];
         got.drops      = data[79:48];
         got.can_accept = data[80];
         got.rejected   = data[81];
         if (pending_verdicts.size() == 0) begin
            log_fault({"result with no request waiting: ", describe(got)});
            return;
         end
         want = pending_verdicts[0];
         pending_verdicts.delete(0);
         if (got.shown !== want.shown || got.handle !== want.handle ||
             got.delay !== want.delay || got.drops !== want.drops ||
             got.can_accept !== want.can_accept || got.rejected !== want.rejected)
            log_fault({"mismatch: expected ", describe(want), " got ", describe(got)});
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // frame_handle, frame_pts_us, frame_duration_us, clock_now_us, clock_valid, zero pad
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // command
   logic [CMD_W-1:0]      req_tuser = CMD_FLUSH;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // shown_handle, next_delay_us, drop_count, can_accept, push_rejected, zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // frame_valid
   logic                  rsp_tuser;
   logic                  csr_we = 1'b0;
   logic                  csr_index = CSR_DEFAULT_DELAY;
   logic [DELAY_W-1:0]    csr_wdata = '0;

   pacing_scoreboard_type sb;
   int  issued;
   int  gap_pct;
   int  quiet_ticks;
   bit  calm;
   bit  long_hold_due;

   video_frame_pacing_queue_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_ticks <= 0;
      else
         quiet_ticks <= quiet_ticks + 1;
      if (quiet_ticks >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stall bursts, one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [TIME_W-1:0] rand40();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_W-1:0];
   endfunction

   function automatic pacing_request_type random_request(logic [CMD_W-1:0] cmd);
      pacing_request_type r;
      r.cmd    = cmd;
      r.handle = HANDLE_W'($urandom);
      r.pts    = rand40();
      r.dur    = $urandom;
      r.now    = rand40();
      r.now_ok = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Offer one request, hold until taken, then maybe idle; valid stays high otherwise
   task automatic issue(input pacing_request_type r);
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= {7'd0, r.now_ok, r.now, r.dur, r.pts, r.handle};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
      issued++;
      if (!calm && $urandom_range(1, 100) <= gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic do_cmd(input logic [CMD_W-1:0] cmd);
      issue(random_request(cmd));
   endtask

   task automatic do_push(input logic [HANDLE_W-1:0] h, input logic [TIME_W-1:0] p,
                          input logic [DUR_W-1:0] d);
      pacing_request_type r;
      r = random_request(CMD_PUSH);
      r.handle = h;
      r.pts    = p;
      r.dur    = d;
      issue(r);
   endtask

   task automatic do_render(input logic [TIME_W-1:0] now, input logic ok);
      pacing_request_type r;
      r = random_request(CMD_RENDER);
      r.now    = now;
      r.now_ok = ok;
      issue(r);
   endtask

   // Drop valid and wait until the block has nothing left in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending_verdicts.size() > 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic program_regs(input logic [DELAY_W-1:0] dly, input logic [FILL_W-1:0] fill);
      csr_we    <= 1'b1;
      csr_index <= CSR_DEFAULT_DELAY;
      csr_wdata <= dly;
      @(posedge clock);
      sb.write_reg(CSR_DEFAULT_DELAY, dly);
      csr_index <= CSR_FILL_LIMIT;
      csr_wdata <= {{(DELAY_W-FILL_W){1'b0}}, fill};
      @(posedge clock);
      sb.write_reg(CSR_FILL_LIMIT, {{(DELAY_W-FILL_W){1'b0}}, fill});
      csr_we <= 1'b0;
   endtask

   task automatic run_directed();
      gap_pct = 0;
      do_render(40'd0, 1'b1);                        // stopped, empty
      do_cmd(CMD_START);
      do_render(40'd5, 1'b1);                        // empty queue
      do_push(16'hFFFF, 40'd0, 32'hFFFF_FFFF);
      do_render(40'hFF_FFFF_FFFF, 1'b0);             // clock not valid
      do_render(40'hFF_FFFF_FFFF, 1'b1);             // single frame stays
      do_push(16'h0000, 40'hFF_FFFF_FFFF, 32'd0);
      do_push(16'h1234, 40'd100, 32'd50);
      do_push(16'h5678, 40'd200, 32'd100);
      do_push(16'hABCD, 40'd300, 32'd1);             // queue full
      do_render(40'd0, 1'b1);
      do_cmd(CMD_FLUSH);
      do_push(16'd10, 40'd1000, 32'd400);
      do_push(16'd11, 40'd2000, 32'd400);
      do_push(16'd12, 40'd3000, 32'd400);
      do_push(16'd13, 40'd4000, 32'd400);
      do_render(40'd3500, 1'b1);                     // skip one, current frame expired
      do_push(16'd14, 40'd5000, 32'd400);
      do_render(40'hFF_FFFF_FFFF, 1'b1);             // every later frame due
      do_cmd(CMD_STOP);
      do_render(40'd6000, 1'b1);                     // stopped with frames held
      do_cmd(CMD_SPARE_LO);
      do_cmd(CMD_SPARE_HI);
      do_cmd(CMD_FLUSH);
   endtask

   // Well-formed stretch: fill the queue with paced frames, then render along the timeline
   task automatic play_episode();
      logic [TIME_W-1:0] base, now, p;
      logic [DUR_W-1:0]  d;
      int unsigned       step, nfr, nrend;
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      step    = $urandom_range(1, 50000);
      base    = rand40();
      if ($urandom_range(0, 3) != 0)
         base[TIME_W-1:TIME_W-4] = '0;
      if ($urandom_range(0, 2) == 0)
         do_cmd(CMD_FLUSH);
      do_cmd(($urandom_range(0, 7) != 0) ? CMD_START : CMD_STOP);
      nfr = $urandom_range(1, 5);
      for (int i = 0; i < nfr; i++) begin
         p = base + TIME_W'(i * step);
         if ($urandom_range(0, 7) == 0)
            p = p + TIME_W'($urandom_range(0, 3 * step)) - TIME_W'(step);
         d = ($urandom_range(0, 7) == 0) ? $urandom : step / 2 + $urandom_range(0, step);
         do_push(HANDLE_W'($urandom), p, d);
      end
      now   = base - TIME_W'($urandom_range(0, step));
      nrend = $urandom_range(1, 6);
      for (int i = 0; i < nrend; i++) begin
         now = now + TIME_W'($urandom_range(0, 2 * step));
         if ($urandom_range(0, 9) == 0)
            now = now + TIME_W'(nfr * step);
         if ($urandom_range(0, 14) == 0)
            do_push(HANDLE_W'($urandom), now + TIME_W'(step), step);
         if ($urandom_range(0, 19) == 0) begin
            do_cmd(CMD_STOP);
            do_render(now, 1'b1);
            do_cmd(CMD_START);
         end
         if ($urandom_range(0, 9) == 0)
            do_render(rand40(), 1'b0);
         else
            do_render(now, 1'b1);
      end
   endtask

   initial begin
      logic [DELAY_W-1:0] phase_delay [6];
      logic [FILL_W-1:0]  phase_fill [6];
      sb = new();
      issued = 0;
      gap_pct = 0;
      quiet_ticks = 0;
      calm = 1'b0;
      long_hold_due = 1'b0;
      phase_delay = '{32'd0, $urandom, 32'd12345, $urandom, 32'd10000, 32'hFFFF_FFFF};
      phase_fill  = '{3'd1, 3'd3, 3'd0, 3'd7, 3'd2, 3'd4};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         program_regs(phase_delay[ph], phase_fill[ph]);
         if (ph == 1)
            long_hold_due = 1'b1;
         if (ph == 5)
            calm = 1'b1;
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
               gap_pct = $urandom_range(0, 30);
               do_cmd(CMD_W'($urandom_range(0, 7)));
            end else begin
               play_episode();
            end
         end
      end
      settle();
      repeat (20) @(posedge clock);
      if (sb.faults == 0 && sb.pending_verdicts.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
